FILE: rtl/core/abts_pkg.sv
package abts_pkg;

  localparam int NODE_COUNT_DEF = 128;

  localparam logic [2:0] CMD_INS_ROOT  = 3'd0;
  localparam logic [2:0] CMD_INS_LEFT  = 3'd1;
  localparam logic [2:0] CMD_INS_RIGHT = 3'd2;
  localparam logic [2:0] CMD_REMOVE    = 3'd3;
  localparam logic [2:0] CMD_LEAF_Q    = 3'd4;
  localparam logic [2:0] CMD_RD_ROOT   = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_PRESENT  = 3'd2;
  localparam logic [2:0] ST_MISSING  = 3'd3;
  localparam logic [2:0] ST_NOT_LEAF = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [6:0]         node_index;
    logic signed [31:0] node_value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               leaf_flag;
    logic signed [31:0] root_value;
  } out_t;

endpackage

FILE: rtl/core/abts_ram.sv
module abts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/abts_ctrl.sv
module abts_ctrl
  import abts_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   start,
  output logic                                                   busy,
  input  in_t                                                    in_item,
  output logic                                                   out_valid,
  output out_t                                                   out_item,
  output logic                                                   occ_we,
  output logic [(((NODE_COUNT/2) > 1) ? $clog2(NODE_COUNT/2) : 1)-1:0] occ_waddr,
  output logic [1:0]                                             occ_wdata,
  output logic [(((NODE_COUNT/2) > 1) ? $clog2(NODE_COUNT/2) : 1)-1:0] occ_raddr,
  input  logic [1:0]                                             occ_rdata,
  output logic                                                   val_we,
  output logic [$clog2(NODE_COUNT)-1:0]                          val_waddr,
  output logic [31:0]                                            val_wdata,
  input  logic [31:0]                                            val_rdata
);

  localparam int ROWS = NODE_COUNT / 2;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int VAW  = $clog2(NODE_COUNT);
  localparam int XW   = ($clog2(NODE_COUNT + 1) > 9) ? $clog2(NODE_COUNT + 1) : 9;
  localparam logic [XW-1:0]  NC_X     = XW'(NODE_COUNT);
  localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RD1, S_RD2} state_t;

  state_t           state_r, state_nxt;
  logic [RAW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [2:0]       cmd_r;
  logic [6:0]       idx_r;
  logic [31:0]      val_r;
  logic             own_occ_r;
  logic [1:0]       own_row_r;
  logic             root_occ_r, root_occ_nxt;
  logic             out_valid_r;
  out_t             out_item_r, out_item_nxt;

  logic [XW-1:0]    in_idx_x, idx_x, lchild, rchild, child;
  logic [RAW-1:0]   own_raddr_in, own_raddr_r;
  logic             own_occ_now;
  logic             l_occ, r_occ, leaf, is_left, c_in, c_occ;

  assign in_idx_x     = XW'(in_item.node_index);
  assign idx_x        = XW'(idx_r);
  assign own_raddr_in = RAW'((in_idx_x - XW'(1)) >> 1);
  assign own_raddr_r  = RAW'((idx_x - XW'(1)) >> 1);
  assign lchild       = XW'({idx_r, 1'b1});
  assign rchild       = XW'({idx_r, 1'b0}) + XW'(2);
  assign l_occ        = (lchild < NC_X) && occ_rdata[0];
  assign r_occ        = (rchild < NC_X) && occ_rdata[1];
  assign leaf         = !l_occ && !r_occ;
  assign is_left      = (cmd_r == CMD_INS_LEFT);
  assign child        = is_left ? lchild : rchild;
  assign c_in         = (child < NC_X);
  assign c_occ        = is_left ? occ_rdata[0] : occ_rdata[1];

  always_comb begin
    if (idx_r == 7'd0) begin
      own_occ_now = root_occ_r;
    end else if (idx_x < NC_X) begin
      own_occ_now = idx_r[0] ? occ_rdata[0] : occ_rdata[1];
    end else begin
      own_occ_now = 1'b0;
    end
  end

  assign occ_raddr = (state_r == S_IDLE) ? own_raddr_in : RAW'(idx_x);
  assign val_wdata = val_r;

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    root_occ_nxt = root_occ_r;
    out_item_nxt = out_item_r;
    occ_we       = 1'b0;
    occ_waddr    = clr_cnt_r;
    occ_wdata    = 2'b00;
    val_we       = 1'b0;
    val_waddr    = '0;
    unique case (state_r)
      S_CLEAR: begin
        occ_we = 1'b1;
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + RAW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        state_nxt = S_RD2;
      end
      S_RD2: begin
        state_nxt               = S_IDLE;
        out_item_nxt.status     = ST_OK;
        out_item_nxt.leaf_flag  = 1'b0;
        out_item_nxt.root_value = '0;
        unique case (cmd_r) inside
          CMD_INS_ROOT: begin
            if (root_occ_r) begin
              out_item_nxt.status = ST_PRESENT;
            end else begin
              root_occ_nxt = 1'b1;
              val_we       = 1'b1;
            end
          end
          CMD_INS_LEFT, CMD_INS_RIGHT: begin
            if (!own_occ_r || !c_in) begin
              out_item_nxt.status = ST_BAD;
            end else if (c_occ) begin
              out_item_nxt.status = ST_PRESENT;
            end else begin
              occ_we    = 1'b1;
              occ_waddr = RAW'(idx_x);
              occ_wdata = occ_rdata | (is_left ? 2'b01 : 2'b10);
              val_we    = 1'b1;
              val_waddr = VAW'(child);
            end
          end
          CMD_REMOVE: begin
            if (!own_occ_r) begin
              out_item_nxt.status = ST_MISSING;
            end else if (!leaf) begin
              out_item_nxt.status = ST_NOT_LEAF;
            end else if (idx_r == 7'd0) begin
              root_occ_nxt = 1'b0;
            end else begin
              occ_we    = 1'b1;
              occ_waddr = own_raddr_r;
              occ_wdata = own_row_r & (idx_r[0] ? 2'b10 : 2'b01);
            end
          end
          CMD_LEAF_Q: begin
            if (!own_occ_r) begin
              out_item_nxt.status = ST_MISSING;
            end else begin
              out_item_nxt.leaf_flag = leaf;
            end
          end
          CMD_RD_ROOT: begin
            if (!root_occ_r) begin
              out_item_nxt.status = ST_EMPTY;
            end else begin
              out_item_nxt.root_value = val_rdata;
            end
          end
          default: begin
            out_item_nxt.status = ST_BAD;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      root_occ_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      root_occ_r  <= root_occ_nxt;
      out_valid_r <= (state_r == S_RD2);
    end
    out_item_r <= out_item_nxt;
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_item.cmd;
      idx_r <= in_item.node_index;
      val_r <= in_item.node_value;
    end
    if (state_r == S_RD1) begin
      own_occ_r <= own_occ_now;
      own_row_r <= occ_rdata;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/core/array_binary_tree_store_top.sv
// An accepted transaction passes S_RD1, then S_RD2; out_valid is registered
//   from S_RD2. A new one is taken only in S_IDLE. The occupancy RAM has one
//   read port and is read twice per transaction (own row, then child row).
// Reset: synchronous, active low; afterwards busy stays high while the
//   occupancy RAM is cleared one row per cycle.
// Each result is held for exactly one cycle; the receiver cannot stall.
module array_binary_tree_store_top
  import abts_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  localparam int ROWS = NODE_COUNT / 2;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int VAW  = $clog2(NODE_COUNT);

  logic           occ_we;
  logic [RAW-1:0] occ_waddr, occ_raddr;
  logic [1:0]     occ_wdata, occ_rdata;
  logic           val_we;
  logic [VAW-1:0] val_waddr, val_raddr;
  logic [31:0]    val_wdata, val_rdata;

  assign val_raddr = '0;

  abts_ram #(
    .WIDTH (2),
    .DEPTH (ROWS)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  abts_ram #(
    .WIDTH (32),
    .DEPTH (NODE_COUNT)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  abts_ctrl #(
    .NODE_COUNT (NODE_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .occ_we    (occ_we),
    .occ_waddr (occ_waddr),
    .occ_wdata (occ_wdata),
    .occ_raddr (occ_raddr),
    .occ_rdata (occ_rdata),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .val_rdata (val_rdata)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_we || val_we) |-> busy)
    else $error("memory write outside a transaction or clear pass");

endmodule
